// ===== rtl/core/assert_macros.svh =====
// assertion macros used by the checker file
// depends on nothing; include by bare file name
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// plain property, sampled on the rising edge, off during reset
`define SAMP_ASSERT(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// same-cycle implication
`define SAMP_ASSERT_IMP(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define SAMP_ASSERT_NXT(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== rtl/core/samp_pkg.sv =====
// types, character codes and helpers of the sam record field parser
// depends on nothing; compiled first
package samp_pkg;

  localparam logic [7:0] ChTab   = 8'd9;
  localparam logic [7:0] ChNl    = 8'd10;
  localparam logic [7:0] ChVt    = 8'd11;
  localparam logic [7:0] ChFf    = 8'd12;
  localparam logic [7:0] ChCr    = 8'd13;
  localparam logic [7:0] ChSpace = 8'd32;
  localparam logic [7:0] ChPlus  = 8'd43;
  localparam logic [7:0] ChMinus = 8'd45;
  localparam logic [7:0] Ch0     = 8'd48;
  localparam logic [7:0] Ch9     = 8'd57;
  localparam logic [7:0] ChAt    = 8'd64;
  localparam logic [7:0] ChA     = 8'd65;
  localparam logic [7:0] ChM     = 8'd77;
  localparam logic [7:0] ChN     = 8'd78;
  localparam logic [7:0] ChS     = 8'd83;

  localparam logic [4:0] FldFlag     = 5'd1;
  localparam logic [4:0] FldPos      = 5'd3;
  localparam logic [4:0] FldMapq     = 5'd4;
  localparam logic [4:0] FldCigar    = 5'd5;
  localparam logic [4:0] FldMate     = 5'd7;
  localparam logic [4:0] FldTlen     = 5'd8;
  localparam logic [4:0] FldSeq      = 5'd9;
  localparam logic [4:0] FldQual     = 5'd10;
  localparam logic [4:0] FldFirstTag = 5'd11;
  localparam logic [4:0] FldMax      = 5'd31;

  localparam logic [2:0] FbiMax      = 3'd7;
  localparam logic [2:0] FbiTagName  = 3'd2;
  localparam logic [2:0] FbiTagValue = 3'd5;

  localparam logic [32:0] NumCap    = 33'h1_0000_0000;
  localparam logic [15:0] OffAbsent = 16'hFFFF;

  localparam int unsigned CmdDepth = 2;

  typedef enum logic [1:0] {
    PH_SKIP,
    PH_SIGN,
    PH_DIGITS,
    PH_DONE
  } samp_phase_e;

  typedef enum logic [1:0] {
    TAG_NONE,
    TAG_AS,
    TAG_NM
  } samp_tag_e;

  typedef enum logic [2:0] {
    TGT_NONE,
    TGT_FLAG,
    TGT_POS,
    TGT_MAPQ,
    TGT_MATE,
    TGT_TLEN,
    TGT_AS,
    TGT_NM
  } samp_tgt_e;

  typedef enum logic [1:0] {
    OFS_CIGAR,
    OFS_SEQ,
    OFS_QUAL
  } samp_ofs_e;

  // one command from the classifier to the back end
  typedef struct packed {
    logic        off_en;
    samp_ofs_e   off_sel;
    logic [15:0] off_val;
    logic        dig_en;
    logic        dig_first;
    logic [3:0]  dig;
    samp_tgt_e   tgt;
    logic        neg;
    logic        emit;
    logic        header;
  } samp_cmd_t;

  // where a finished field goes
  function automatic samp_tgt_e samp_target(logic [4:0] fld, logic [2:0] fbi,
                                            samp_tag_e tag);
    samp_tgt_e t;
    t = TGT_NONE;
    if (fbi != 3'd0) begin
      case (fld)
        FldFlag: t = TGT_FLAG;
        FldPos:  t = TGT_POS;
        FldMapq: t = TGT_MAPQ;
        FldMate: t = TGT_MATE;
        FldTlen: t = TGT_TLEN;
        default: begin
          if (fld >= FldFirstTag && fbi >= FbiTagName) begin
            if (tag == TAG_AS) begin
              t = TGT_AS;
            end else if (tag == TAG_NM) begin
              t = TGT_NM;
            end
          end
        end
      endcase
    end
    return t;
  endfunction

endpackage

// ===== rtl/core/samp_if.sv =====
// valid/ready channels of the sam record field parser: byte in, record out
// depends on nothing
interface samp_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] byte_value;
  logic       ends_line;

  modport source (output valid, byte_value, ends_line, input ready);
  modport sink   (input valid, byte_value, ends_line, output ready);
endinterface

interface samp_out_if;
  logic               valid;
  logic               ready;
  logic        [15:0] flag_bits;
  logic signed [31:0] ref_pos;
  logic        [7:0]  map_quality;
  logic signed [31:0] mate_pos;
  logic signed [31:0] template_len;
  logic signed [31:0] align_score;
  logic signed [31:0] edit_distance;
  logic        [15:0] cigar_offset;
  logic        [15:0] seq_offset;
  logic        [15:0] qual_offset;
  logic               is_header;

  modport source (output valid, flag_bits, ref_pos, map_quality, mate_pos, template_len,
                  align_score, edit_distance, cigar_offset, seq_offset, qual_offset,
                  is_header, input ready);
  modport sink   (input valid, flag_bits, ref_pos, map_quality, mate_pos, template_len,
                  align_score, edit_distance, cigar_offset, seq_offset, qual_offset,
                  is_header, output ready);
endinterface

// ===== rtl/core/samp_front.sv =====
// byte classifier: field count, offsets, tag and number phase tracking
// depends on samp_pkg and samp_in_if; emits samp_cmd_t beats to the queue
module samp_front #(
  parameter int unsigned LINE_BYTES = 65536
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  samp_in_if.sink             in_i,
  output samp_pkg::samp_cmd_t cmd_o,
  output logic                cmd_valid_o,
  input  logic                cmd_ready_i
);
  import samp_pkg::*;

  localparam logic [16:0] OffLimit = 17'(LINE_BYTES - 1);

  logic [4:0]  fld_q, fld_d;
  logic [15:0] off_q, off_d;
  logic [2:0]  fbi_q, fbi_d;
  samp_phase_e ph_q, ph_d;
  logic        neg_q, neg_d;
  samp_tag_e   tag_q, tag_d;
  logic        hdr_q, hdr_d;

  logic [7:0]  b;
  logic        accept, is_nl, is_tab, ends, active, hdr_line, cons;
  logic        is_digit, is_space, is_sign, numeric;
  samp_tag_e   tag_c;
  samp_phase_e ph_c;
  logic        neg_c, dig_en, dig_first;
  logic [2:0]  fbi_c;

  assign b           = in_i.byte_value;
  assign in_i.ready  = cmd_ready_i;
  assign accept      = in_i.valid && in_i.ready;
  assign is_nl       = (b == ChNl);
  assign is_tab      = (b == ChTab);
  assign ends        = is_nl || in_i.ends_line;
  assign active      = !is_nl && ({1'b0, off_q} < OffLimit);
  assign hdr_line    = hdr_q || (active && off_q == 16'd0 && b == ChAt);
  assign cons        = active && !hdr_line;
  assign is_digit    = b inside {[Ch0:Ch9]};
  assign is_space    = b inside {ChSpace, ChVt, ChFf, ChCr};
  assign is_sign     = (b == ChPlus) || (b == ChMinus);
  assign fbi_c       = (fbi_q == FbiMax) ? FbiMax : fbi_q + 3'd1;

  // tag detection and number phase for a content byte other than tab
  always_comb begin
    tag_c = tag_q;
    if (fld_q >= FldFirstTag) begin
      if (fbi_q == 3'd0) begin
        tag_c = (b == ChA) ? TAG_AS : ((b == ChN) ? TAG_NM : TAG_NONE);
      end else if (fbi_q == 3'd1 &&
                   !((tag_q == TAG_AS && b == ChS) || (tag_q == TAG_NM && b == ChM))) begin
        tag_c = TAG_NONE;
      end
    end
    numeric = (fld_q inside {FldFlag, FldPos, FldMapq, FldMate, FldTlen}) ||
              (fld_q >= FldFirstTag && tag_c != TAG_NONE && fbi_q >= FbiTagValue);
    ph_c      = ph_q;
    neg_c     = neg_q;
    dig_en    = 1'b0;
    dig_first = 1'b0;
    if (numeric) begin
      case (ph_q)
        PH_SKIP: begin
          if (is_space) begin
            ph_c = PH_SKIP;
          end else if (is_sign) begin
            neg_c = (b == ChMinus);
            ph_c  = PH_SIGN;
          end else if (is_digit) begin
            dig_en    = 1'b1;
            dig_first = 1'b1;
            ph_c      = PH_DIGITS;
          end else begin
            ph_c = PH_DONE;
          end
        end
        PH_SIGN: begin
          if (is_digit) begin
            dig_en    = 1'b1;
            dig_first = 1'b1;
            ph_c      = PH_DIGITS;
          end else begin
            ph_c = PH_DONE;
          end
        end
        PH_DIGITS: begin
          if (is_digit) begin
            dig_en = 1'b1;
          end else begin
            ph_c = PH_DONE;
          end
        end
        default: ph_c = ph_q;
      endcase
    end
  end

  // next state
  always_comb begin
    fld_d = fld_q;
    off_d = off_q;
    fbi_d = fbi_q;
    ph_d  = ph_q;
    neg_d = neg_q;
    tag_d = tag_q;
    hdr_d = hdr_q;
    if (accept) begin
      if (ends) begin
        fld_d = '0;
        off_d = '0;
        fbi_d = '0;
        ph_d  = PH_SKIP;
        neg_d = 1'b0;
        tag_d = TAG_NONE;
        hdr_d = 1'b0;
      end else if (active) begin
        off_d = off_q + 16'd1;
        hdr_d = hdr_line;
        if (cons) begin
          if (is_tab) begin
            if (fld_q != FldMax) begin
              fld_d = fld_q + 5'd1;
            end
            fbi_d = '0;
            ph_d  = PH_SKIP;
            neg_d = 1'b0;
            tag_d = TAG_NONE;
          end else begin
            fbi_d = fbi_c;
            tag_d = tag_c;
            ph_d  = ph_c;
            neg_d = neg_c;
          end
        end
      end
    end
  end

  // command to the back end
  always_comb begin
    cmd_o         = '0;
    cmd_o.off_sel = OFS_CIGAR;
    cmd_o.tgt     = TGT_NONE;
    cmd_o.off_val = off_q;
    if (cons && fbi_q == 3'd0) begin
      case (fld_q)
        FldCigar: begin
          cmd_o.off_en  = 1'b1;
          cmd_o.off_sel = OFS_CIGAR;
        end
        FldSeq: begin
          cmd_o.off_en  = 1'b1;
          cmd_o.off_sel = OFS_SEQ;
        end
        FldQual: begin
          cmd_o.off_en  = 1'b1;
          cmd_o.off_sel = OFS_QUAL;
        end
        default: cmd_o.off_en = 1'b0;
      endcase
    end
    if (cons && is_tab) begin
      cmd_o.tgt = samp_target(fld_q, fbi_q, tag_q);
      cmd_o.neg = neg_q;
    end else if (ends && !hdr_line) begin
      if (cons) begin
        cmd_o.tgt = samp_target(fld_q, fbi_c, tag_c);
        cmd_o.neg = neg_c;
      end else begin
        cmd_o.tgt = samp_target(fld_q, fbi_q, tag_q);
        cmd_o.neg = neg_q;
      end
    end
    cmd_o.dig_en    = cons && !is_tab && dig_en;
    cmd_o.dig_first = dig_first;
    cmd_o.dig       = b[3:0];
    cmd_o.emit      = ends;
    cmd_o.header    = hdr_line;
    cmd_valid_o     = accept && (cmd_o.off_en || cmd_o.dig_en ||
                                 cmd_o.tgt != TGT_NONE || cmd_o.emit);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fld_q <= '0;
      off_q <= '0;
      fbi_q <= '0;
      ph_q  <= PH_SKIP;
      neg_q <= 1'b0;
      tag_q <= TAG_NONE;
      hdr_q <= 1'b0;
    end else begin
      fld_q <= fld_d;
      off_q <= off_d;
      fbi_q <= fbi_d;
      ph_q  <= ph_d;
      neg_q <= neg_d;
      tag_q <= tag_d;
      hdr_q <= hdr_d;
    end
  end

endmodule

// ===== rtl/core/samp_cmd_fifo.sv =====
// short command queue between classifier and back end
// depends on samp_pkg for the beat type and depth
module samp_cmd_fifo (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                push_i,
  input  samp_pkg::samp_cmd_t data_i,
  output logic                full_o,
  input  logic                pop_i,
  output logic                valid_o,
  output samp_pkg::samp_cmd_t data_o
);
  import samp_pkg::*;

  localparam int unsigned PtrW = (CmdDepth > 1) ? $clog2(CmdDepth) : 1;
  localparam int unsigned CntW = $clog2(CmdDepth + 1);
  localparam logic [PtrW-1:0] PtrLast = PtrW'(CmdDepth - 1);
  localparam logic [CntW-1:0] CntFull = CntW'(CmdDepth);

  samp_cmd_t       mem_q [CmdDepth];
  logic [PtrW-1:0] wr_q, wr_d, rd_q, rd_d;
  logic [CntW-1:0] cnt_q, cnt_d;
  logic            do_push, do_pop;

  assign full_o  = (cnt_q == CntFull);
  assign valid_o = (cnt_q != '0);
  assign data_o  = mem_q[rd_q];
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && valid_o;

  always_comb begin
    wr_d  = wr_q;
    rd_d  = rd_q;
    cnt_d = cnt_q;
    if (do_push) begin
      wr_d = (wr_q == PtrLast) ? '0 : wr_q + 1'b1;
    end
    if (do_pop) begin
      rd_d = (rd_q == PtrLast) ? '0 : rd_q + 1'b1;
    end
    if (do_push && !do_pop) begin
      cnt_d = cnt_q + 1'b1;
    end else if (do_pop && !do_push) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_q] <= data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      wr_q  <= wr_d;
      rd_q  <= rd_d;
      cnt_q <= cnt_d;
    end
  end

endmodule

// ===== rtl/core/samp_back.sv =====
// back end: decimal accumulate, saturate and store fields, record output register
// depends on samp_pkg and samp_out_if
module samp_back (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cmd_valid_i,
  input  samp_pkg::samp_cmd_t cmd_i,
  output logic                cmd_pop_o,
  samp_out_if.source          out_o
);
  import samp_pkg::*;

  typedef struct packed {
    logic [15:0] flag;
    logic [31:0] pos;
    logic [7:0]  mapq;
    logic [31:0] mate;
    logic [31:0] tlen;
    logic [31:0] as_val;
    logic [31:0] nm_val;
    logic [15:0] cigar;
    logic [15:0] seq;
    logic [15:0] qual;
  } rec_t;

  localparam rec_t RecClear = '{cigar: OffAbsent, seq: OffAbsent, qual: OffAbsent,
                                default: '0};

  logic [32:0] acc_q, acc_d, acc_new;
  logic [36:0] prod;
  logic        bv_q, bv_d;
  samp_cmd_t   bcmd_q;
  logic [32:0] bacc_q;
  rec_t        rec_q, rec_d, rec_upd;
  rec_t        out_q;
  logic        out_hdr_q;
  logic        ov_q, ov_d;
  logic        out_free, b_fire, b_emit;
  logic [31:0] val32;
  logic [15:0] val16;
  logic [7:0]  val8;

  assign out_free  = !ov_q || out_o.ready;
  assign b_fire    = bv_q && (!bcmd_q.emit || out_free);
  assign b_emit    = b_fire && bcmd_q.emit;
  assign cmd_pop_o = cmd_valid_i && (!bv_q || b_fire);

  // times ten plus digit, magnitude held at 2^32
  assign prod = {1'b0, acc_q, 3'b000} + {3'b000, acc_q, 1'b0} + {33'd0, cmd_i.dig};

  always_comb begin
    acc_new = acc_q;
    if (cmd_i.dig_en) begin
      if (cmd_i.dig_first) begin
        acc_new = {29'd0, cmd_i.dig};
      end else begin
        acc_new = (prod > {4'd0, NumCap}) ? NumCap : prod[32:0];
      end
    end
    acc_d = acc_q;
    bv_d  = bv_q && !b_fire;
    if (cmd_pop_o) begin
      bv_d  = 1'b1;
      acc_d = (cmd_i.tgt != TGT_NONE || cmd_i.emit) ? '0 : acc_new;
    end
  end

  // saturation of the finished magnitude
  always_comb begin
    if (!bcmd_q.neg) begin
      val32 = (bacc_q > 33'h0_7FFF_FFFF) ? 32'h7FFF_FFFF : bacc_q[31:0];
      val16 = (bacc_q > 33'h0_0000_FFFF) ? 16'hFFFF : bacc_q[15:0];
      val8  = (bacc_q > 33'h0_0000_00FF) ? 8'hFF : bacc_q[7:0];
    end else begin
      val32 = (bacc_q > 33'h0_8000_0000) ? 32'h8000_0000 : 32'd0 - bacc_q[31:0];
      val16 = '0;
      val8  = '0;
    end
  end

  always_comb begin
    rec_upd = rec_q;
    if (bcmd_q.off_en) begin
      case (bcmd_q.off_sel)
        OFS_CIGAR: rec_upd.cigar = bcmd_q.off_val;
        OFS_SEQ:   rec_upd.seq   = bcmd_q.off_val;
        OFS_QUAL:  rec_upd.qual  = bcmd_q.off_val;
        default:   rec_upd.cigar = rec_q.cigar;
      endcase
    end
    case (bcmd_q.tgt)
      TGT_FLAG: rec_upd.flag   = val16;
      TGT_POS:  rec_upd.pos    = val32;
      TGT_MAPQ: rec_upd.mapq   = val8;
      TGT_MATE: rec_upd.mate   = val32;
      TGT_TLEN: rec_upd.tlen   = val32;
      TGT_AS:   rec_upd.as_val = val32;
      TGT_NM:   rec_upd.nm_val = val32;
      default:  rec_upd.flag   = rec_q.flag;
    endcase
    rec_d = rec_q;
    if (b_fire) begin
      rec_d = bcmd_q.emit ? RecClear : rec_upd;
    end
    ov_d = b_emit ? 1'b1 : (ov_q && !out_o.ready);
  end

  always_ff @(posedge clk_i) begin
    if (cmd_pop_o) begin
      bcmd_q <= cmd_i;
      bacc_q <= acc_new;
    end
    if (b_emit) begin
      out_q     <= bcmd_q.header ? '0 : rec_upd;
      out_hdr_q <= bcmd_q.header;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      acc_q <= '0;
      bv_q  <= 1'b0;
      rec_q <= RecClear;
      ov_q  <= 1'b0;
    end else begin
      acc_q <= acc_d;
      bv_q  <= bv_d;
      rec_q <= rec_d;
      ov_q  <= ov_d;
    end
  end

  assign out_o.valid         = ov_q;
  assign out_o.flag_bits     = out_q.flag;
  assign out_o.ref_pos       = out_q.pos;
  assign out_o.map_quality   = out_q.mapq;
  assign out_o.mate_pos      = out_q.mate;
  assign out_o.template_len  = out_q.tlen;
  assign out_o.align_score   = out_q.as_val;
  assign out_o.edit_distance = out_q.nm_val;
  assign out_o.cigar_offset  = out_q.cigar;
  assign out_o.seq_offset    = out_q.seq;
  assign out_o.qual_offset   = out_q.qual;
  assign out_o.is_header     = out_hdr_q;

endmodule

// ===== rtl/core/sam_record_field_parser.sv =====
// top level of the sam record field parser: classifier, command queue, back end
// depends on samp_pkg, samp_if, samp_front, samp_cmd_fifo and samp_back
//
// Takes one byte of a tab-separated SAM alignment line per beat, one beat per clock,
// and gives one record beat when a newline or a byte marked ends_line arrives. A
// byte can enter every cycle; in_i.ready drops only when the two-entry command queue is
// full, which happens only while a finished record waits on out_o.ready. The record
// for a line is registered in the command queue by the edge that takes its ending
// byte, then passes through the finish stage (saturation and field store) and the
// output register before it is offered. Numeric fields follow strtol rules with
// saturation; a line starting with '@' gives a zeroed record with is_header set;
// bytes at offset LINE_BYTES-1 and beyond are ignored until the line ends.
module sam_record_field_parser #(
  parameter int unsigned LINE_BYTES = 65536
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  samp_in_if.sink     in_i,
  samp_out_if.source  out_o
);
  import samp_pkg::*;

  samp_cmd_t push_cmd, pop_cmd;
  logic      push_valid, fifo_full, fifo_valid, fifo_pop;

  samp_front #(
    .LINE_BYTES(LINE_BYTES)
  ) u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_i       (in_i),
    .cmd_o      (push_cmd),
    .cmd_valid_o(push_valid),
    .cmd_ready_i(!fifo_full)
  );

  samp_cmd_fifo u_fifo (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (push_valid),
    .data_i (push_cmd),
    .full_o (fifo_full),
    .pop_i  (fifo_pop),
    .valid_o(fifo_valid),
    .data_o (pop_cmd)
  );

  samp_back u_back (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cmd_valid_i(fifo_valid),
    .cmd_i      (pop_cmd),
    .cmd_pop_o  (fifo_pop),
    .out_o      (out_o)
  );

endmodule

// ===== rtl/core/samp_checker.sv =====
// port-level checks of the sam record field parser, bound to the top level
// depends on assert_macros.svh
`include "assert_macros.svh"

module samp_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        out_valid_i,
  input logic        out_ready_i,
  input logic [15:0] flag_bits_i,
  input logic [31:0] ref_pos_i,
  input logic [7:0]  map_quality_i,
  input logic [31:0] mate_pos_i,
  input logic [31:0] template_len_i,
  input logic [31:0] align_score_i,
  input logic [31:0] edit_distance_i,
  input logic [15:0] cigar_offset_i,
  input logic [15:0] seq_offset_i,
  input logic [15:0] qual_offset_i,
  input logic        is_header_i
);

  // a stalled record beat stays offered
  `SAMP_ASSERT_NXT(a_out_hold, clk_i, rst_ni, out_valid_i && !out_ready_i, out_valid_i, "record beat dropped while stalled")

  // header records carry nothing else
  `SAMP_ASSERT_IMP(a_hdr_zero, clk_i, rst_ni, out_valid_i && is_header_i, flag_bits_i == 16'd0 && ref_pos_i == 32'd0 && map_quality_i == 8'd0 && mate_pos_i == 32'd0 && template_len_i == 32'd0 && align_score_i == 32'd0 && edit_distance_i == 32'd0 && cigar_offset_i == 16'd0 && seq_offset_i == 16'd0 && qual_offset_i == 16'd0, "header record with nonzero field")

  // field starts come in line order, absent ones at all ones
  `SAMP_ASSERT(a_off_order, clk_i, rst_ni, !out_valid_i || (cigar_offset_i <= seq_offset_i && seq_offset_i <= qual_offset_i), "field offsets out of order")

endmodule

bind sam_record_field_parser samp_checker u_samp_checker (
  .clk_i          (clk_i),
  .rst_ni         (rst_ni),
  .out_valid_i    (out_o.valid),
  .out_ready_i    (out_o.ready),
  .flag_bits_i    (out_o.flag_bits),
  .ref_pos_i      (out_o.ref_pos),
  .map_quality_i  (out_o.map_quality),
  .mate_pos_i     (out_o.mate_pos),
  .template_len_i (out_o.template_len),
  .align_score_i  (out_o.align_score),
  .edit_distance_i(out_o.edit_distance),
  .cigar_offset_i (out_o.cigar_offset),
  .seq_offset_i   (out_o.seq_offset),
  .qual_offset_i  (out_o.qual_offset),
  .is_header_i    (out_o.is_header)
);

// ===== tb/tb_top.sv =====
// self-checking bench for sam_record_field_parser: streams SAM text lines byte by byte
// and checks every record beat against a line parser kept in the bench
// depends on samp_pkg, samp_if and the parser rtl
module tb_top;
  import samp_pkg::*;

  localparam int unsigned LineBytes  = 65536;
  localparam int unsigned CycleLimit = 600000;

  typedef struct packed {
    logic        [15:0] flag_bits;
    logic signed [31:0] ref_pos;
    logic        [7:0]  map_quality;
    logic signed [31:0] mate_pos;
    logic signed [31:0] template_len;
    logic signed [31:0] align_score;
    logic signed [31:0] edit_distance;
    logic        [15:0] cigar_offset;
    logic        [15:0] seq_offset;
    logic        [15:0] qual_offset;
    logic               is_header;
  } sam_rec_t;

  class record_scoreboard;
    logic [4:0]      field_no;
    int unsigned     line_pos;
    logic [2:0]      char_in_field;
    longint unsigned mag;
    bit              minus;
    samp_phase_e     phase;
    samp_tag_e       tag;
    bit              at_header;
    sam_rec_t        partial;
    sam_rec_t        awaited[$];
    int unsigned     noted;
    int unsigned     headers;
    int unsigned     checked;
    int unsigned     failures;

    function new();
      restart_line();
    endfunction

    function void restart_field();
      char_in_field = '0;
      mag = 0;
      minus = 1'b0;
      phase = PH_SKIP;
      tag = TAG_NONE;
    endfunction

    function void restart_line();
      field_no = '0;
      line_pos = 0;
      at_header = 1'b0;
      restart_field();
      partial = '0;
      partial.cigar_offset = OffAbsent;
      partial.seq_offset = OffAbsent;
      partial.qual_offset = OffAbsent;
    endfunction

    function longint clip(longint v, longint lo, longint hi);
      return v < lo ? lo : (v > hi ? hi : v);
    endfunction

    function void close_field();
      longint v;
      longint lo;
      longint hi;
      if (char_in_field == 0) return;
      lo = -64'sd2147483648;
      hi = 64'sd2147483647;
      v = minus ? -longint'(mag) : longint'(mag);
      case (field_no)
        FldFlag: partial.flag_bits = 16'(clip(v, 0, 65535));
        FldPos:  partial.ref_pos = 32'(clip(v, lo, hi));
        FldMapq: partial.map_quality = 8'(clip(v, 0, 255));
        FldMate: partial.mate_pos = 32'(clip(v, lo, hi));
        FldTlen: partial.template_len = 32'(clip(v, lo, hi));
        default: begin
          if (field_no >= FldFirstTag && char_in_field >= FbiTagName) begin
            if (tag == TAG_AS) partial.align_score = 32'(clip(v, lo, hi));
            else if (tag == TAG_NM) partial.edit_distance = 32'(clip(v, lo, hi));
          end
        end
      endcase
    endfunction

    function void digit_step(logic [7:0] b);
      bit              is_digit;
      longint unsigned d;
      longint unsigned n;
      is_digit = b >= Ch0 && b <= Ch9;
      d = 64'(4'(b - Ch0));
      case (phase)
        PH_SKIP: begin
          if (b == ChSpace || b == ChVt || b == ChFf || b == ChCr) return;
          if (b == ChPlus || b == ChMinus) begin
            minus = b == ChMinus;
            phase = PH_SIGN;
          end else if (is_digit) begin
            mag = d;
            phase = PH_DIGITS;
          end else begin
            phase = PH_DONE;
          end
        end
        PH_SIGN: begin
          if (is_digit) begin
            mag = d;
            phase = PH_DIGITS;
          end else begin
            phase = PH_DONE;
          end
        end
        PH_DIGITS: begin
          if (is_digit) begin
            n = mag * 10 + d;
            mag = n > NumCap ? 64'(NumCap) : n;
          end else begin
            phase = PH_DONE;
          end
        end
        default: ;
      endcase
    endfunction

    function void take_char(logic [7:0] b);
      logic [2:0] idx;
      bit         numeric;
      if (line_pos >= LineBytes - 1) return;
      if (line_pos == 0 && b == ChAt) at_header = 1'b1;
      if (at_header) begin
        line_pos = (line_pos + 1) & 32'hFFFF;
        return;
      end
      idx = char_in_field;
      if (idx == 0) begin
        case (field_no)
          FldCigar: partial.cigar_offset = 16'(line_pos);
          FldSeq:   partial.seq_offset = 16'(line_pos);
          FldQual:  partial.qual_offset = 16'(line_pos);
          default: ;
        endcase
      end
      if (b == ChTab) begin
        close_field();
        if (field_no < FldMax) field_no++;
        restart_field();
      end else begin
        numeric = field_no == FldFlag || field_no == FldPos || field_no == FldMapq ||
                  field_no == FldMate || field_no == FldTlen;
        if (field_no >= FldFirstTag) begin
          if (idx == 0) begin
            tag = b == ChA ? TAG_AS : (b == ChN ? TAG_NM : TAG_NONE);
          end else if (idx == 1 && !((tag == TAG_AS && b == ChS) ||
                                     (tag == TAG_NM && b == ChM))) begin
            tag = TAG_NONE;
          end
          if (tag != TAG_NONE && idx >= FbiTagValue) numeric = 1'b1;
        end
        if (numeric) digit_step(b);
        if (char_in_field < FbiMax) char_in_field++;
      end
      line_pos = (line_pos + 1) & 32'hFFFF;
    endfunction

    function void note_byte(logic [7:0] b, logic last);
      sam_rec_t r;
      if (b != ChNl) take_char(b);
      if (b != ChNl && !last) return;
      if (at_header) begin
        r = '0;
        r.is_header = 1'b1;
        headers++;
      end else begin
        close_field();
        r = partial;
        r.is_header = 1'b0;
      end
      awaited.push_back(r);
      noted++;
      restart_line();
    endfunction

    function int unsigned pending();
      return awaited.size();
    endfunction

    function string show(sam_rec_t r);
      return $sformatf({"flag=%0d pos=%0d mapq=%0d mpos=%0d tlen=%0d as=%0d nm=%0d ",
                        "cigar@%0d seq@%0d qual@%0d hdr=%0b"},
                       r.flag_bits, r.ref_pos, r.map_quality, r.mate_pos, r.template_len,
                       r.align_score, r.edit_distance, r.cigar_offset, r.seq_offset,
                       r.qual_offset, r.is_header);
    endfunction

    function void check_record(sam_rec_t got);
      sam_rec_t want;
      string    diff;
      if (awaited.size() == 0) begin
        failures++;
        if (failures <= 10) $display("record beat with none outstanding: %s", show(got));
        return;
      end
      want = awaited.pop_front();
      checked++;
      diff = "";
      if (want.flag_bits !== got.flag_bits) diff = {diff, " flag_bits"};
      if (want.ref_pos !== got.ref_pos) diff = {diff, " ref_pos"};
      if (want.map_quality !== got.map_quality) diff = {diff, " map_quality"};
      if (want.mate_pos !== got.mate_pos) diff = {diff, " mate_pos"};
      if (want.template_len !== got.template_len) diff = {diff, " template_len"};
      if (want.align_score !== got.align_score) diff = {diff, " align_score"};
      if (want.edit_distance !== got.edit_distance) diff = {diff, " edit_distance"};
      if (want.cigar_offset !== got.cigar_offset) diff = {diff, " cigar_offset"};
      if (want.seq_offset !== got.seq_offset) diff = {diff, " seq_offset"};
      if (want.qual_offset !== got.qual_offset) diff = {diff, " qual_offset"};
      if (want.is_header !== got.is_header) diff = {diff, " is_header"};
      if (diff != "") begin
        failures++;
        if (failures <= 10) begin
          $display("record %0d differs in%s\n  expected %s\n  actual   %s",
                   checked, diff, show(want), show(got));
        end
      end
    endfunction
  endclass

  logic clk_i;
  logic rst_ni;

  samp_in_if  in_if ();
  samp_out_if out_if ();

  sam_record_field_parser #(
    .LINE_BYTES(LineBytes)
  ) u_dut (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .in_i  (in_if),
    .out_o (out_if)
  );

  record_scoreboard sb;
  logic [7:0]       line_q[$];
  bit               sink_eager;
  int unsigned      stall_left;
  int unsigned      stall_draw;
  int unsigned      cycle_count = 0;
  int unsigned      bytes_sent;
  int unsigned      marked_ends;
  int unsigned      longest_line;
  sam_rec_t         got;

  initial begin
    clk_i = 1'b0;
    forever #4 clk_i = ~clk_i;
  end

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CycleLimit) begin
      $display("timeout after %0d cycles, %0d records outstanding", cycle_count, sb.pending());
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  // record sink with random back-pressure
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_if.ready <= 1'b0;
      stall_left <= 0;
    end else if (out_if.ready) begin
      if (out_if.valid) begin
        got.flag_bits = out_if.flag_bits;
        got.ref_pos = out_if.ref_pos;
        got.map_quality = out_if.map_quality;
        got.mate_pos = out_if.mate_pos;
        got.template_len = out_if.template_len;
        got.align_score = out_if.align_score;
        got.edit_distance = out_if.edit_distance;
        got.cigar_offset = out_if.cigar_offset;
        got.seq_offset = out_if.seq_offset;
        got.qual_offset = out_if.qual_offset;
        got.is_header = out_if.is_header;
        sb.check_record(got);
        stall_draw = sink_eager ? 0 : $urandom_range(0, 14);
        if (stall_draw != 0) begin
          out_if.ready <= 1'b0;
          stall_left <= stall_draw;
        end
      end
    end else if (stall_left <= 1) begin
      out_if.ready <= 1'b1;
    end else begin
      stall_left <= stall_left - 1;
    end
  end

  function automatic void put_text(string s);
    for (int i = 0; i < s.len(); i++) line_q.push_back(s[i]);
  endfunction

  function automatic void put_word(int unsigned max_len);
    string alpha;
    alpha = "ACGTNacgt0123456789*=:_.";
    repeat ($urandom_range(1, max_len)) line_q.push_back(alpha[$urandom_range(0, alpha.len() - 1)]);
  endfunction

  function automatic string num_text(int unsigned hi);
    string edges[10] = '{"2147483647", "2147483648", "-2147483648", "-2147483649",
                         "4294967295", "4294967296", "65535", "65536", "256", "-0"};
    string pad;
    string s;
    pad = "";
    case ($urandom_range(0, 9))
      0: pad = " ";
      1: pad = "\013 \014";
      2: pad = "\015";
      default: ;
    endcase
    case ($urandom_range(0, 12))
      0: s = "";
      1: s = "*";
      2: s = $urandom_range(0, 1) ? "-" : "+";
      3: s = $sformatf("-%0d", $urandom_range(0, hi));
      4: s = $sformatf("+%0d", $urandom_range(0, hi));
      5: s = $sformatf("%0d%0d", $urandom(), $urandom());
      6: s = $sformatf("-%0d%0d", $urandom(), $urandom());
      7: s = $sformatf("%0dx%0d", $urandom_range(0, hi), $urandom_range(0, 9));
      8: s = $sformatf("%0d", $urandom());
      9: s = edges[$urandom_range(0, 9)];
      default: s = $sformatf("%0d", $urandom_range(0, hi));
    endcase
    return {pad, s};
  endfunction

  // fills line_q; returns 1 when the line ends on a marked byte instead of a newline
  function automatic bit build_random_line();
    string       shorts[6] = '{"AS", "NM:", "A", "NM:i", "AM:i:3", "NS:i:4"};
    int unsigned kind;
    line_q.delete();
    kind = $urandom_range(0, 15);
    if (kind == 0) begin
      repeat ($urandom_range(1, 24)) line_q.push_back(8'($urandom_range(0, 255)));
    end else if (kind == 1) begin
      line_q.push_back(ChAt);
      put_word(12);
    end else if (kind != 2) begin
      put_word(8);
      put_text({"\t", num_text(4095), "\t"});
      put_word(5);
      put_text({"\t", num_text(250000000), "\t", num_text(70), "\t"});
      put_word(6);
      put_text("\t");
      put_word(4);
      put_text({"\t", num_text(250000000), "\t", num_text(900), "\t"});
      put_word(8);
      put_text("\t");
      put_word(8);
      if ($urandom_range(0, 7) == 0) repeat ($urandom_range(1, 24)) line_q.push_back(ChTab);
      repeat ($urandom_range(0, 4)) begin
        put_text("\t");
        case ($urandom_range(0, 7))
          0, 1, 2: put_text({"AS:i:", num_text(300)});
          3, 4:    put_text({"NM:i:", num_text(40)});
          5:       put_text("XS:i:17");
          6:       put_text(shorts[$urandom_range(0, 5)]);
          default: put_word(6);
        endcase
      end
      if (kind == 3) line_q = line_q[0:$urandom_range(0, line_q.size() - 1)];
      if ($urandom_range(0, 5) == 0) begin
        line_q[$urandom_range(0, line_q.size() - 1)] = 8'($urandom_range(0, 255));
      end
    end
    return line_q.size() != 0 && $urandom_range(0, 4) == 0;
  endfunction

  task automatic send_byte(logic [7:0] b, logic last, int unsigned gap);
    if (gap != 0) begin
      in_if.valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_if.valid <= 1'b1;
    in_if.byte_value <= b;
    in_if.ends_line <= last;
    @(posedge clk_i);
    while (!in_if.ready) @(posedge clk_i);
    sb.note_byte(b, last);
    bytes_sent++;
  endtask

  task automatic send_line(bit marked, bit no_gaps);
    bit src_eager;
    src_eager = no_gaps || $urandom_range(0, 3) == 0;
    sink_eager = $urandom_range(0, 3) == 0;
    if (line_q.size() > longest_line) longest_line = line_q.size();
    foreach (line_q[i]) begin
      send_byte(line_q[i], marked && i == line_q.size() - 1,
                src_eager ? 0 : $urandom_range(0, 14));
    end
    if (marked && line_q.size() != 0) begin
      marked_ends++;
    end else begin
      send_byte(ChNl, 1'($urandom_range(0, 1)), src_eager ? 0 : $urandom_range(0, 14));
    end
    line_q.delete();
  endtask

  task automatic wait_drained();
    in_if.valid <= 1'b0;
    @(posedge clk_i);
    while (sb.pending() != 0) @(posedge clk_i);
  endtask

  initial begin
    int unsigned n_lines;
    int unsigned start_bytes;
    bit          marked;
    sb = new();
    in_if.valid <= 1'b0;
    in_if.byte_value <= '0;
    in_if.ends_line <= 1'b0;
    rst_ni <= 1'b0;
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;

    // directed lines
    put_text("@HD\tVN:1.6\tSO:coordinate");
    send_line(1'b0, 1'b0);
    send_line(1'b0, 1'b0);
    put_text({"r1\t4095\tchr1\t2147483647\t255\t10M\t=\t-2147483648\t-350\tACGT\tIIII",
              "\tAS:i:-12\tNM:i:3"});
    send_line(1'b0, 1'b0);
    put_text({"r2\t99999999999\tc\t99999999999\t-5\t*\t*\t-99999999999\t+4294967296\t*\t*",
              "\tAS:i:4294967297\tNM:i:-4294967296"});
    send_line(1'b1, 1'b0);
    put_text("r3\t \013\014\015+12x\tc\t- 5\t+\t\t\t \t-\t\t");
    send_line(1'b0, 1'b0);
    put_text("r4\t1");
    line_q.push_back(8'h00);
    put_text("2\tc\t7");
    send_line(1'b0, 1'b0);
    put_text("r5\t0\tc\t1\t1\t*\t*\t0\t0\t*\t*\tAS\tNM:i\tXS:i:5\tAM:i:3\tNM:i:8\tAS:i:9\tAS:");
    send_line(1'b0, 1'b0);
    put_text("r6");
    repeat (34) line_q.push_back(ChTab);
    put_text("NM:i:+7\tAS:i: 15");
    send_line(1'b0, 1'b0);
    put_text("9");
    send_line(1'b1, 1'b0);
    put_text("@");
    send_line(1'b1, 1'b0);
    put_text("r@\t3\tc\t@5");
    send_line(1'b0, 1'b0);
    put_text("r7\t16\tc\t5");
    send_line(1'b1, 1'b0);
    wait_drained();

    // random lines
    start_bytes = bytes_sent;
    n_lines = 0;
    while (bytes_sent - start_bytes < 1200 || n_lines < 12) begin
      marked = build_random_line();
      send_line(marked, 1'b0);
      n_lines++;
      if (n_lines == 6) wait_drained();
    end

    in_if.valid <= 1'b0;
    @(posedge clk_i);
    while (sb.pending() != 0) @(posedge clk_i);
    repeat (8) @(posedge clk_i);
    if (sb.pending() != 0) begin
      sb.failures += sb.pending();
      $display("%0d records never arrived", sb.pending());
    end
    $display("sent %0d bytes in %0d lines (%0d header, %0d closed by end marker)",
             bytes_sent, sb.noted, sb.headers, marked_ends);
    $display("checked %0d records, longest line %0d bytes, %0d failures",
             sb.checked, longest_line, sb.failures);
    if (sb.failures == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule

// ===== files.f =====
+incdir+rtl/core
rtl/core/samp_pkg.sv
rtl/core/samp_if.sv
rtl/core/samp_front.sv
rtl/core/samp_cmd_fifo.sv
rtl/core/samp_back.sv
rtl/core/sam_record_field_parser.sv
rtl/core/samp_checker.sv
tb/tb_top.sv
